/* hdl/mmsq_pkg.sv */
package mmsq_pkg;

  localparam int CNT_W    = 7;
  localparam int LV_W     = 9;
  localparam int PADDR_W  = 3;
  localparam int QDEPTH   = 2;
  localparam int STEP_ITS = 32;
  localparam int CODE_ITS = 9;

  localparam logic [LV_W-1:0] LEVELS_RESET = 9'd256;
  localparam logic [LV_W-1:0] LEVELS_MIN   = 9'd2;
  localparam logic [LV_W-1:0] LEVELS_MAX   = 9'd256;

  localparam logic REG_LEVELS = 1'b0;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } mmsq_item_t;

  typedef struct packed {
    logic        [7:0]  code;
    logic signed [31:0] minimum;
    logic        [31:0] step;
    logic               overflow;
    logic               last_code;
  } mmsq_result_t;

  // one finished vector handed from the front to the back
  typedef struct packed {
    logic signed [31:0] vmin;
    logic signed [31:0] vmax;
    logic [CNT_W-1:0]   count;
    logic               dropped;
    logic               bank;
  } mmsq_desc_t;

  typedef struct packed {
    logic done;
    logic bank;
  } mmsq_free_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_LOAD,
    BS_DIV,
    BS_EMIT
  } mmsq_bstate_t;

endpackage

/* hdl/mmsq_queue.sv */
module mmsq_queue import mmsq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  mmsq_desc_t push_data,
  input  logic       pop,
  output logic       pop_valid,
  output mmsq_desc_t pop_data
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FW = $clog2(QDEPTH + 1);

  mmsq_desc_t       entries [0:QDEPTH-1];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [FW-1:0]    fill;

  assign pop_valid = (fill != '0);
  assign pop_data  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QDEPTH - 1)) ? '0 : PW'(wp + 1'b1);
      end
      if (pop && pop_valid) begin
        rp <= (rp == PW'(QDEPTH - 1)) ? '0 : PW'(rp + 1'b1);
      end
      case ({push, pop && pop_valid})
        2'b10:   fill <= FW'(fill + 1'b1);
        2'b01:   fill <= FW'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* hdl/mmsq_front.sv */
module mmsq_front import mmsq_pkg::*; #(
  parameter int MAX_DIM = 64,
  parameter int IW      = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  mmsq_item_t       item,
  output logic             push,
  output mmsq_desc_t       push_data,
  input  mmsq_free_t       free,
  input  logic             rd_en,
  input  logic [IW:0]      rd_addr,
  output logic [31:0]      rd_data
);

  logic [31:0]        mem [0:(2<<IW)-1];
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic signed [31:0] vmin;
  logic signed [31:0] vmin_next;
  logic signed [31:0] vmax;
  logic signed [31:0] vmax_next;
  logic               dropped;
  logic               dropped_next;
  logic               wr_bank;
  logic [1:0]         busy;
  logic               take;
  logic               full;
  logic               wr;

  assign item_ready = !busy[wr_bank];
  assign take       = item_valid && item_ready;
  assign full       = (cnt == CNT_W'(MAX_DIM));
  assign wr         = take && !full;

  always_comb begin
    cnt_next     = cnt;
    vmin_next    = vmin;
    vmax_next    = vmax;
    dropped_next = dropped;
    if (take) begin
      if (full) begin
        dropped_next = 1'b1;
      end else begin
        cnt_next = CNT_W'(cnt + 1'b1);
        if (cnt == '0) begin
          vmin_next = item.sample;
          vmax_next = item.sample;
        end else begin
          if (item.sample < vmin) begin
            vmin_next = item.sample;
          end
          if (item.sample > vmax) begin
            vmax_next = item.sample;
          end
        end
      end
    end
  end

  assign push              = take && item.last;
  assign push_data.vmin    = vmin_next;
  assign push_data.vmax    = vmax_next;
  assign push_data.count   = cnt_next;
  assign push_data.dropped = dropped_next;
  assign push_data.bank    = wr_bank;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[{wr_bank, cnt[IW-1:0]}] <= item.sample;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      vmin    <= '0;
      vmax    <= '0;
      dropped <= 1'b0;
      wr_bank <= 1'b0;
      busy    <= '0;
    end else begin
      if (push) begin
        // hand the bank to the back and start the next vector in the other one
        cnt     <= '0;
        vmin    <= '0;
        vmax    <= '0;
        dropped <= 1'b0;
        wr_bank <= !wr_bank;
      end else begin
        cnt     <= cnt_next;
        vmin    <= vmin_next;
        vmax    <= vmax_next;
        dropped <= dropped_next;
      end
      for (int b = 0; b < 2; b++) begin
        if (push && (wr_bank == 1'(b))) begin
          busy[b] <= 1'b1;
        end else if (free.done && (free.bank == 1'(b))) begin
          busy[b] <= 1'b0;
        end
      end
    end
  end

endmodule

/* hdl/mmsq_back.sv */
module mmsq_back import mmsq_pkg::*; #(
  parameter int IW = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LV_W-1:0]  lv,
  input  logic             q_valid,
  input  mmsq_desc_t       q_data,
  output logic             pop,
  output mmsq_free_t       free,
  output logic             rd_en,
  output logic [IW:0]      rd_addr,
  input  logic [31:0]      rd_data,
  output logic             result_valid,
  input  logic             result_ready,
  output mmsq_result_t     result
);

  localparam int DCW = $clog2(STEP_ITS);
  localparam int PW  = 32 + LV_W;

  mmsq_bstate_t     state;
  mmsq_bstate_t     state_next;
  mmsq_desc_t       cur;
  logic [31:0]      range_q;
  logic             zero_q;
  logic [31:0]      dq;
  logic [LV_W-1:0]  drem;
  logic [DCW-1:0]   dcnt;
  logic [CNT_W-1:0] icnt;

  logic             adv;
  logic             ld;
  logic             div_run;
  logic             issue;
  logic             final_beat;
  logic [LV_W:0]    dt;
  logic             dge;

  // pipeline
  logic             p0v, p0l;
  logic             p1v, p1l;
  logic [31:0]      off;
  logic             p2v, p2l;
  logic [PW-1:0]    prod;
  logic [31:0]      s_rem  [1:CODE_ITS];
  logic [8:0]       s_low  [1:CODE_ITS];
  logic [8:0]       s_q    [1:CODE_ITS];
  logic             s_v    [1:CODE_ITS];
  logic             s_l    [1:CODE_ITS];
  logic [31:0]      c_rem  [0:CODE_ITS-1];
  logic [8:0]       c_low  [0:CODE_ITS-1];
  logic [8:0]       c_q    [0:CODE_ITS-1];
  logic             c_v    [0:CODE_ITS-1];
  logic             c_l    [0:CODE_ITS-1];
  logic [8:0]       qf;
  logic [LV_W-1:0]  lv_top;
  logic [7:0]       code_c;

  assign adv        = !result_valid || result_ready;
  assign final_beat = result_valid && result_ready && result.last_code;

  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE: if (q_valid) state_next = BS_LOAD;
      BS_LOAD: state_next = BS_DIV;
      BS_DIV:  if (dcnt == DCW'(STEP_ITS - 1)) state_next = BS_EMIT;
      BS_EMIT: if (final_beat) state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    ld      = 1'b0;
    div_run = 1'b0;
    issue   = 1'b0;
    case (state)
      BS_IDLE: pop = q_valid;
      BS_LOAD: ld = 1'b1;
      BS_DIV:  div_run = 1'b1;
      BS_EMIT: issue = adv && (icnt != cur.count);
      default: ;
    endcase
  end

  assign free.done = final_beat;
  assign free.bank = cur.bank;
  assign rd_en     = adv;
  assign rd_addr   = {cur.bank, icnt[IW-1:0]};

  // step = range / levels, one quotient bit a cycle
  assign dt  = {drem, dq[31]};
  assign dge = (dt >= {1'b0, lv});

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (ld) begin
      range_q <= 32'(cur.vmax - cur.vmin);
      zero_q  <= (cur.vmax == cur.vmin);
      dq      <= 32'(cur.vmax - cur.vmin);
      drem    <= '0;
    end else if (div_run) begin
      drem <= dge ? LV_W'(dt - {1'b0, lv}) : dt[LV_W-1:0];
      dq   <= {dq[30:0], dge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
      dcnt  <= '0;
      icnt  <= '0;
    end else begin
      state <= state_next;
      if (ld) begin
        dcnt <= '0;
        icnt <= '0;
      end else begin
        if (div_run) begin
          dcnt <= DCW'(dcnt + 1'b1);
        end
        if (issue) begin
          icnt <= CNT_W'(icnt + 1'b1);
        end
      end
    end
  end

  // sample read, offset, product, then one code bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p0v <= 1'b0;
      p1v <= 1'b0;
      p2v <= 1'b0;
    end else if (adv) begin
      p0v <= issue;
      p1v <= p0v;
      p2v <= p1v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0l  <= (CNT_W'(icnt + 1'b1) == cur.count);
      p1l  <= p0l;
      off  <= rd_data - cur.vmin;
      p2l  <= p1l;
      prod <= {{LV_W{1'b0}}, off} * {32'b0, lv};
    end
  end

  always_comb begin
    c_rem[0] = prod[PW-1:9];
    c_low[0] = prod[8:0];
    c_q[0]   = '0;
    c_v[0]   = p2v;
    c_l[0]   = p2l;
    for (int j = 1; j < CODE_ITS; j++) begin
      c_rem[j] = s_rem[j];
      c_low[j] = s_low[j];
      c_q[j]   = s_q[j];
      c_v[j]   = s_v[j];
      c_l[j]   = s_l[j];
    end
  end

  for (genvar j = 1; j <= CODE_ITS; j++) begin : g_cdiv
    logic [32:0] t;
    logic        ge;

    assign t  = {c_rem[j-1], c_low[j-1][8]};
    assign ge = (t >= {1'b0, range_q});

    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[j] <= 1'b0;
      end else if (adv) begin
        s_v[j] <= c_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_rem[j] <= ge ? 32'(t - {1'b0, range_q}) : t[31:0];
        s_low[j] <= {c_low[j-1][7:0], 1'b0};
        s_q[j]   <= {c_q[j-1][7:0], ge};
        s_l[j]   <= c_l[j-1];
      end
    end
  end

  // clamp the top edge to the last class; a flat vector codes to zero
  assign qf     = s_q[CODE_ITS];
  assign lv_top = LV_W'(lv - 1'b1);
  assign code_c = zero_q ? 8'd0 : ((qf > lv_top) ? lv_top[7:0] : qf[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s_v[CODE_ITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.code      <= code_c;
      result.minimum   <= cur.vmin;
      result.step      <= dq;
      result.overflow  <= cur.dropped;
      result.last_code <= s_l[CODE_ITS];
    end
  end

endmodule

/* hdl/min_max_scalar_quantizer_unit.sv */
// Min/max scalar quantizer with 8-bit codes.
// Input channel (item_valid/item_ready/item): one signed Q16.16 sample a
// beat; the beat with last set closes the vector. Up to MAX_DIM samples are
// kept; further ones are dropped and flag overflow on every result.
// Output channel (result_valid/result_ready/result): one beat per stored
// sample, in input order, each with its code, the vector minimum, the step
// and the overflow flag; last_code marks the final beat.
// The APB port holds levels (reset 256; below 2 acts as 2, above 256 as 256).
// Samples are taken one a cycle while the bank being filled is free. Two
// sample banks let the next vector load while the previous one is still
// being coded. Before the first result is offered, the back end takes the
// vector from the queue and runs the bit-serial step divider; each sample
// then passes the bank read, the offset, the multiply, the nine-stage code
// divider and the output register. Results then leave one a cycle while
// the receiver is ready. A stalled receiver freezes the code pipeline;
// loading continues until both banks hold vectors awaiting output. Reset
// empties both banks and the queue; no clearing pass is needed.
module min_max_scalar_quantizer_unit import mmsq_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  mmsq_item_t         item,
  output logic               result_valid,
  input  logic               result_ready,
  output mmsq_result_t       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [LV_W-1:0] levels;
  logic [LV_W-1:0] lv_eff;
  logic            push;
  mmsq_desc_t      push_data;
  logic            pop;
  logic            q_valid;
  mmsq_desc_t      q_data;
  mmsq_free_t      free;
  logic            rd_en;
  logic [IW:0]     rd_addr;
  logic [31:0]     rd_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LEVELS) ? {{(32 - LV_W){1'b0}}, levels} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= LEVELS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LEVELS)) begin
      levels <= pwdata[LV_W-1:0];
    end
  end

  assign lv_eff = (levels < LEVELS_MIN) ? LEVELS_MIN :
                  (levels > LEVELS_MAX) ? LEVELS_MAX : levels;

  mmsq_front #(
    .MAX_DIM (MAX_DIM),
    .IW      (IW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (push),
    .push_data  (push_data),
    .free       (free),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  mmsq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  mmsq_back #(
    .IW (IW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .lv           (lv_eff),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .free         (free),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* sim/mmsq_code_checker.sv */
`timescale 1ns / 100ps

module mmsq_code_checker import mmsq_pkg::*; #(
  parameter int VEC_CAP = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  mmsq_item_t         item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  mmsq_result_t       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 codes_due
);

  localparam logic [PADDR_W-1:0] LEVELS_ADDR = PADDR_W'(4 * REG_LEVELS);

  logic signed [31:0] held [VEC_CAP];
  int unsigned        held_count;
  logic signed [31:0] vec_lo, vec_hi;
  logic               vec_dropped;
  logic [LV_W-1:0]    levels_reg;
  mmsq_result_t       due_codes [$];

  // Work out the codes of the vector just closed, then clear for the next one.
  function automatic void quantize_vector();
    logic [LV_W-1:0]   lv;
    longint unsigned   classes, span, stride, offset, q;
    mmsq_result_t      r;
    lv = (levels_reg < LEVELS_MIN) ? LEVELS_MIN :
         (levels_reg > LEVELS_MAX) ? LEVELS_MAX : levels_reg;
    classes = lv;
    span    = longint'(vec_hi) - longint'(vec_lo);
    stride  = span / classes;
    for (int i = 0; i < held_count; i++) begin
      q = 0;
      if (span != 0) begin
        offset = longint'(held[i]) - longint'(vec_lo);
        q = offset * classes / span;
        if (q > classes - 1) q = classes - 1;
      end
      r.code      = q[7:0];
      r.minimum   = vec_lo;
      r.step      = stride[31:0];
      r.overflow  = vec_dropped;
      r.last_code = (i + 1 == held_count);
      due_codes.insert(due_codes.size(), r);
    end
    held_count  = 0;
    vec_lo      = '0;
    vec_hi      = '0;
    vec_dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    mmsq_result_t want;
    if (rst) begin
      held_count  = 0;
      vec_lo      = '0;
      vec_hi      = '0;
      vec_dropped = 1'b0;
      levels_reg  = LEVELS_RESET;
      due_codes.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LEVELS_ADDR)
        levels_reg = pwdata[LV_W-1:0];

      if (result_valid && result_ready) begin
        if (due_codes.size() == 0) begin
          $error("result beat with no code due: code %0d", result.code);
          mismatches++;
        end else begin
          want = due_codes.pop_front();
          if (result.code !== want.code) begin
            $error("code: expected %0d, got %0d", want.code, result.code);
            mismatches++;
          end
          if (result.minimum !== want.minimum) begin
            $error("minimum: expected %0d, got %0d", want.minimum, result.minimum);
            mismatches++;
          end
          if (result.step !== want.step) begin
            $error("step: expected %0d, got %0d", want.step, result.step);
            mismatches++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, result.overflow);
            mismatches++;
          end
          if (result.last_code !== want.last_code) begin
            $error("last_code: expected %0d, got %0d", want.last_code, result.last_code);
            mismatches++;
          end
        end
      end

      if (item_valid && item_ready) begin
        if (held_count < VEC_CAP) begin
          if (held_count == 0) begin
            vec_lo = item.sample;
            vec_hi = item.sample;
          end else begin
            if (item.sample < vec_lo) vec_lo = item.sample;
            if (item.sample > vec_hi) vec_hi = item.sample;
          end
          held[held_count] = item.sample;
          held_count++;
        end else begin
          vec_dropped = 1'b1;
        end
        if (item.last) quantize_vector();
      end
    end
    codes_due = due_codes.size();
  end

endmodule

/* sim/min_max_scalar_quantizer_unit_tb.sv */
`timescale 1ns / 100ps

module min_max_scalar_quantizer_unit_tb import mmsq_pkg::*;;

  localparam int VEC_CAP      = 64;
  localparam int RANDOM_ITEMS = 420;
  localparam int SETTLE       = 64;
  localparam logic [PADDR_W-1:0] LEVELS_ADDR = PADDR_W'(4 * REG_LEVELS);

  typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_FLAT, SPREAD_CORNER} spread_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  mmsq_item_t         item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  mmsq_result_t       result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int mismatches;
  int codes_due;
  int items_sent = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  logic [LV_W-1:0] level_plan [0:9] = '{9'd2, 9'd0, 9'd1, 9'd257, 9'd511,
                                         9'd255, 9'd128, 9'd3, 9'd256, 9'd300};

  always #5 clk = ~clk;

  min_max_scalar_quantizer_unit dut (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mmsq_code_checker #(.VEC_CAP(VEC_CAP)) checker_i (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .codes_due
  );

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_item(input logic signed [31:0] x, input logic is_last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= {x, is_last};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_vector(input int len, input spread_t shape);
    logic signed [31:0] base, x;
    int unsigned        spread;
    base   = $urandom;
    spread = 32'd1 << $urandom_range(0, 20);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SPREAD_FULL:   x = $urandom;
        SPREAD_NARROW: x = base + $urandom_range(0, spread);
        SPREAD_FLAT:   x = base;
        default: begin
          case ($urandom_range(0, 4))
            0:       x = 32'sh8000_0000;
            1:       x = 32'sh7FFF_FFFF;
            2:       x = 32'sh0000_0000;
            3:       x = -32'sd1;
            default: x = 32'sh0001_0000;
          endcase
        end
      endcase
      send_item(x, i == len - 1);
    end
  endtask

  // Hold the sender until every code due has come back.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (codes_due != 0) @(negedge clk);
  endtask

  task automatic write_levels(input logic [LV_W-1:0] lv);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LEVELS_ADDR;
    pwdata  <= {23'($urandom), lv};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: when rx_idle is set, stall a random number of cycles after each beat it takes.
  initial begin
    int  hold;
    logic took;
    hold = 0;
    forever begin
      @(posedge clk);
      took = result_valid && result_ready;
      @(negedge clk);
      if (took) hold = rx_idle ? $urandom_range(0, 12) : 0;
      if (hold != 0) begin
        result_ready <= 1'b0;
        hold--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    int        phase, len, target;
    spread_t   shape;
    logic [LV_W-1:0] lv;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // lone sample: zero range
    send_item(32'sh8000_0000, 1'b1);
    // full signed span
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sh0001_0000, 1'b1);
    // all components equal
    send_item(32'sh1234_5678, 1'b0);
    send_item(32'sh1234_5678, 1'b0);
    send_item(32'sh1234_5678, 1'b1);
    // small negative range, exact class boundaries
    send_item(-32'sd4, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(-32'sd2, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b1);
    write_levels(9'd2);
    send_item(32'sd0, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sd2, 1'b0);
    send_item(32'sd3, 1'b1);
    write_levels(9'd256);
    send_item(32'sh0000_00FF, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(32'sh0000_0080, 1'b1);

    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target || phase < 10) begin
      lv = (phase < 10) ? level_plan[phase] : LV_W'($urandom_range(0, 511));
      write_levels(lv);
      tx_idle = (phase % 4) != 1;
      rx_idle = (phase % 4) != 2;
      // one vector past capacity, closing beat dropped
      if (phase == 0) send_vector(VEC_CAP + 1, SPREAD_FULL);
      for (int v = 0; v < 3; v++) begin
        case ($urandom_range(0, 19))
          0:          len = $urandom_range(VEC_CAP + 1, VEC_CAP + 4);
          1, 2, 3:    len = $urandom_range(9, VEC_CAP);
          default:    len = $urandom_range(1, 8);
        endcase
        shape = spread_t'($urandom_range(0, 3));
        send_vector(len, shape);
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && codes_due == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
